/* hw/rtl/maad_pkg.sv */
`timescale 1ns / 1ps
// shared types, constants and register codes of the moving average alert detector
package maad_pkg;

    localparam int WINDOW        = 10;
    localparam int PRESET_SAMPLE = 5700;
    localparam int MIN_MATCHES   = 2;
    localparam int NUM_NBR       = 4;

    localparam int DATA_W  = 16;
    localparam int COUNT_W = 3;
    localparam int SUM_W   = DATA_W + $clog2(WINDOW);
    localparam int SLOT_W  = (WINDOW > 1) ? $clog2(WINDOW) : 1;

    // divide by WINDOW as multiply by a rounded-up reciprocal, exact for SUM_W-bit sums
    localparam int      DIV_SHIFT = SUM_W + $clog2(WINDOW);
    localparam int      RECIP_W   = DIV_SHIFT + 1 - $clog2(WINDOW);
    localparam longint  DIV_RECIP = ((64'd1 << DIV_SHIFT) + WINDOW - 1) / WINDOW;
    localparam int      PROD_W    = SUM_W + RECIP_W;

    localparam logic [DATA_W-1:0] SAMPLE_PRESET = DATA_W'(PRESET_SAMPLE);
    localparam logic [SUM_W-1:0]  SUM_PRESET    = SUM_W'(WINDOW * PRESET_SAMPLE);

    // configuration registers
    localparam int ADDR_W = 3;
    localparam logic REG_THRESHOLD = 1'b0;
    localparam logic REG_TOLERANCE = 1'b1;
    localparam logic [DATA_W-1:0] THRESHOLD_RESET = 16'd6000;
    localparam logic [DATA_W-1:0] TOLERANCE_RESET = 16'd100;

    typedef struct packed {
        logic [DATA_W-1:0] reading;
        logic [DATA_W-1:0] left_value;
        logic [DATA_W-1:0] right_value;
        logic [DATA_W-1:0] up_value;
        logic [DATA_W-1:0] down_value;
        logic [3:0]        neighbour_present;
    } t_in_word;

    typedef struct packed {
        logic [DATA_W-1:0]  average;
        logic               above_threshold;
        logic [COUNT_W-1:0] matched_count;
        logic               alert;
    } t_out_word;

    // neighbour set carried down the pipeline, index 0 left, 1 right, 2 up, 3 down
    typedef struct packed {
        logic [NUM_NBR-1:0][DATA_W-1:0] values;
        logic [NUM_NBR-1:0]             present;
    } t_nbr_set;

endpackage

/* hw/rtl/moving_average_alert_detector.sv */
`timescale 1ns / 1ps
// top level: three-stage moving average alert detector with config port
// an accepted word moves through the stage 1, stage 2 and stage 3 registers in order to the output
// throughput: one word per cycle, held only by output stall through the pipeline
// stage 1 is the ring and running sum, stage 2 the reciprocal multiply, stage 3 the lanes
// reset: synchronous active low, ring preset to 5700, sum to window times 5700,
// threshold 6000, tolerance 100, all pipeline stages empty
module moving_average_alert_detector (
    input  logic                           i_clk,
    input  logic                           i_rst_n,

    // input channel
    input  logic                           i_in_valid,
    input  maad_pkg::t_in_word             i_in_word,
    output logic                           o_in_stall,

    // result channel
    output logic                           o_out_valid,
    output maad_pkg::t_out_word            o_out_word,
    input  logic                           i_out_stall,

    // config port
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [maad_pkg::ADDR_W-1:0]    paddr,
    input  logic [31:0]                    pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready
);

    // config registers
    logic [maad_pkg::DATA_W-1:0] r_threshold;
    logic [maad_pkg::DATA_W-1:0] r_tolerance;
    logic                        cfg_write;
    logic                        reg_sel;

    // pipeline control: each stage moves when the next one is empty or moving
    logic r_v1;
    logic r_v2;
    logic r_v3;
    logic en1;
    logic en2;
    logic en3;
    logic accept;

    // neighbour payload per stage
    maad_pkg::t_nbr_set r_nbr1;
    maad_pkg::t_nbr_set r_nbr2;
    maad_pkg::t_nbr_set in_nbr;

    logic [maad_pkg::SUM_W-1:0]   sum;
    logic [maad_pkg::DATA_W-1:0]  average;
    logic [maad_pkg::NUM_NBR-1:0] match;
    maad_pkg::t_out_word          merged;
    maad_pkg::t_out_word          r_out;

    // ---------------------------------------------------------------- config port
    assign pready    = 1'b1;
    assign reg_sel   = paddr[2];
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold <= maad_pkg::THRESHOLD_RESET;
            r_tolerance <= maad_pkg::TOLERANCE_RESET;
        end else if (cfg_write) begin
            case (reg_sel)
                maad_pkg::REG_THRESHOLD: begin
                    r_threshold <= pwdata[maad_pkg::DATA_W-1:0];
                end
                maad_pkg::REG_TOLERANCE: begin
                    r_tolerance <= pwdata[maad_pkg::DATA_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (reg_sel)
            maad_pkg::REG_THRESHOLD: prdata = 32'(r_threshold);
            maad_pkg::REG_TOLERANCE: prdata = 32'(r_tolerance);
            default:                 prdata = '0;
        endcase
    end

    // ---------------------------------------------------------------- flow control
    assign en3        = !r_v3 || !i_out_stall;
    assign en2        = !r_v2 || en3;
    assign en1        = !r_v1 || en2;
    assign o_in_stall = !en1;
    assign accept     = i_in_valid && en1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (en1) begin
                r_v1 <= i_in_valid;
            end
            if (en2) begin
                r_v2 <= r_v1;
            end
            if (en3) begin
                r_v3 <= r_v2;
            end
        end
    end

    // ---------------------------------------------------------------- stage 1: ring and sum
    // the sum register holds the sum for the word sitting in stage 1; it only moves on accept
    maad_window u_window (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_load    (accept),
        .i_reading (i_in_word.reading),
        .o_sum     (sum)
    );

    always_comb begin
        in_nbr.values[0] = i_in_word.left_value;
        in_nbr.values[1] = i_in_word.right_value;
        in_nbr.values[2] = i_in_word.up_value;
        in_nbr.values[3] = i_in_word.down_value;
        in_nbr.present   = i_in_word.neighbour_present;
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_nbr1 <= in_nbr;
        end
        if (en2) begin
            r_nbr2 <= r_nbr1;
        end
    end

    // ---------------------------------------------------------------- stage 2: mean
    maad_divide u_divide (
        .i_clk     (i_clk),
        .i_en      (en2),
        .i_sum     (sum),
        .o_average (average)
    );

    // ---------------------------------------------------------------- stage 3: lanes and merge
    for (genvar g = 0; g < maad_pkg::NUM_NBR; g++) begin : g_lane
        maad_lane u_lane (
            .i_value     (r_nbr2.values[g]),
            .i_present   (r_nbr2.present[g]),
            .i_average   (average),
            .i_tolerance (r_tolerance),
            .o_match     (match[g])
        );
    end

    maad_merge u_merge (
        .i_match     (match),
        .i_average   (average),
        .i_threshold (r_threshold),
        .o_word      (merged)
    );

    always_ff @(posedge i_clk) begin
        if (en3) begin
            r_out <= merged;
        end
    end

    assign o_out_valid = r_v3;
    assign o_out_word  = r_out;

    // ---------------------------------------------------------------- assertions
    a_empty_after_reset: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !o_out_valid)
        else $error("result valid right after reset");

    a_accept_fills_stage1: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> r_v1)
        else $error("accepted word lost before stage 1");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_word.matched_count <= 3'd4))
        else $error("matched count above neighbour count");

    a_alert_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_word.alert) |->
            (o_out_word.above_threshold && (o_out_word.matched_count >= 3'd2)))
        else $error("alert without threshold and matches");

endmodule

/* hw/rtl/maad_window.sv */
`timescale 1ns / 1ps
// sample ring, write slot and running window sum
module maad_window (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_load,
    input  logic [maad_pkg::DATA_W-1:0]   i_reading,
    output logic [maad_pkg::SUM_W-1:0]    o_sum
);

    logic [maad_pkg::DATA_W-1:0] r_ring [maad_pkg::WINDOW];
    logic [maad_pkg::SLOT_W-1:0] r_slot;
    logic [maad_pkg::SLOT_W-1:0] n_slot;
    logic [maad_pkg::SUM_W-1:0]  r_sum;
    logic [maad_pkg::SUM_W-1:0]  n_sum;

    always_comb begin
        n_sum = r_sum - maad_pkg::SUM_W'(r_ring[r_slot]) + maad_pkg::SUM_W'(i_reading);
        if (r_slot == maad_pkg::SLOT_W'(maad_pkg::WINDOW - 1)) begin
            n_slot = '0;
        end else begin
            n_slot = r_slot + maad_pkg::SLOT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < maad_pkg::WINDOW; i++) begin
                r_ring[i] <= maad_pkg::SAMPLE_PRESET;
            end
            r_slot <= '0;
            r_sum  <= maad_pkg::SUM_PRESET;
        end else if (i_load) begin
            r_ring[r_slot] <= i_reading;
            r_slot         <= n_slot;
            r_sum          <= n_sum;
        end
    end

    assign o_sum = r_sum;

endmodule

/* hw/rtl/maad_divide.sv */
`timescale 1ns / 1ps
// registered divide of the window sum by the window length
module maad_divide (
    input  logic                          i_clk,
    input  logic                          i_en,
    input  logic [maad_pkg::SUM_W-1:0]    i_sum,
    output logic [maad_pkg::DATA_W-1:0]   o_average
);

    localparam logic [maad_pkg::RECIP_W-1:0] RECIP = maad_pkg::RECIP_W'(maad_pkg::DIV_RECIP);

    logic [maad_pkg::PROD_W-1:0] product;
    logic [maad_pkg::DATA_W-1:0] r_average;

    assign product = maad_pkg::PROD_W'(i_sum) * maad_pkg::PROD_W'(RECIP);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_average <= product[maad_pkg::DIV_SHIFT +: maad_pkg::DATA_W];
        end
    end

    assign o_average = r_average;

endmodule

/* hw/rtl/maad_lane.sv */
`timescale 1ns / 1ps
// one neighbour compare lane
module maad_lane (
    input  logic [maad_pkg::DATA_W-1:0] i_value,
    input  logic                        i_present,
    input  logic [maad_pkg::DATA_W-1:0] i_average,
    input  logic [maad_pkg::DATA_W-1:0] i_tolerance,
    output logic                        o_match
);

    logic [maad_pkg::DATA_W-1:0] diff;

    // absolute difference, zero difference is not a match
    assign diff    = (i_value > i_average) ? (i_value - i_average) : (i_average - i_value);
    assign o_match = i_present && (diff != '0) && (diff < i_tolerance);

endmodule

/* hw/rtl/maad_merge.sv */
`timescale 1ns / 1ps
// merges the lane matches with the threshold compare into a result word
module maad_merge (
    input  logic [maad_pkg::NUM_NBR-1:0] i_match,
    input  logic [maad_pkg::DATA_W-1:0]  i_average,
    input  logic [maad_pkg::DATA_W-1:0]  i_threshold,
    output maad_pkg::t_out_word          o_word
);

    logic [maad_pkg::COUNT_W-1:0] count;
    logic                         above;

    always_comb begin
        count = '0;
        for (int i = 0; i < maad_pkg::NUM_NBR; i++) begin
            count = count + maad_pkg::COUNT_W'(i_match[i]);
        end
        above = i_average > i_threshold;

        o_word.average         = i_average;
        o_word.above_threshold = above;
        o_word.matched_count   = count;
        o_word.alert           = above && (count >= maad_pkg::COUNT_W'(maad_pkg::MIN_MATCHES));
    end

endmodule

/* dv/maad_alert_checker.sv */
`timescale 1ns / 1ps
// checker for the moving average alert detector: watches both channels and the config port
module maad_alert_checker (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    input  maad_pkg::t_in_word          i_in_word,
    input  logic                        i_in_stall,
    input  logic                        i_out_valid,
    input  maad_pkg::t_out_word         i_out_word,
    input  logic                        i_out_stall,
    input  logic                        i_psel,
    input  logic                        i_penable,
    input  logic                        i_pwrite,
    input  logic [maad_pkg::ADDR_W-1:0] i_paddr,
    input  logic [31:0]                 i_pwdata,
    input  logic [31:0]                 i_prdata,
    input  logic                        i_pready,
    output int                          o_fail_count,
    output int                          o_pending
);

    logic [maad_pkg::DATA_W-1:0] sample_hist [maad_pkg::WINDOW];
    logic [maad_pkg::SUM_W-1:0]  run_sum;
    int unsigned                 next_slot;
    logic [maad_pkg::DATA_W-1:0] threshold;
    logic [maad_pkg::DATA_W-1:0] tolerance;
    maad_pkg::t_out_word         verdict_q [$];
    int                          miss_count = 0;
    int                          open_count = 0;

    assign o_fail_count = miss_count;
    assign o_pending    = open_count;

    function automatic void check_field(string what, logic [31:0] want, logic [31:0] got);
        if (got !== want) begin
            miss_count++;
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want, got);
        end
    endfunction

    function automatic bit near_average(logic [maad_pkg::DATA_W-1:0] value,
                                        logic [maad_pkg::DATA_W-1:0] avg);
        logic [maad_pkg::DATA_W-1:0] diff;
        diff = (value > avg) ? value - avg : avg - value;
        return (diff != '0) && (diff < tolerance);
    endfunction

    // slide one reading into the window and judge the neighbours against the new mean
    function automatic maad_pkg::t_out_word advance_window(maad_pkg::t_in_word w);
        maad_pkg::t_out_word         verdict;
        logic [maad_pkg::DATA_W-1:0] nbr [maad_pkg::NUM_NBR];
        logic [maad_pkg::DATA_W-1:0] avg;
        int unsigned                 hits;
        nbr[0] = w.left_value;
        nbr[1] = w.right_value;
        nbr[2] = w.up_value;
        nbr[3] = w.down_value;
        hits = 0;
        run_sum = run_sum - sample_hist[next_slot] + w.reading;
        sample_hist[next_slot] = w.reading;
        next_slot = (next_slot + 1 == maad_pkg::WINDOW) ? 0 : next_slot + 1;
        avg = maad_pkg::DATA_W'(run_sum / maad_pkg::WINDOW);
        for (int i = 0; i < maad_pkg::NUM_NBR; i++) begin
            if (w.neighbour_present[i] && near_average(nbr[i], avg))
                hits++;
        end
        verdict.average         = avg;
        verdict.above_threshold = (avg > threshold);
        verdict.matched_count   = maad_pkg::COUNT_W'(hits);
        verdict.alert           = verdict.above_threshold && (hits >= maad_pkg::MIN_MATCHES);
        return verdict;
    endfunction

    always @(posedge i_clk) begin
        maad_pkg::t_out_word want;
        if (!i_rst_n) begin
            for (int i = 0; i < maad_pkg::WINDOW; i++)
                sample_hist[i] = maad_pkg::SAMPLE_PRESET;
            run_sum   = maad_pkg::SUM_PRESET;
            next_slot = 0;
            threshold = maad_pkg::THRESHOLD_RESET;
            tolerance = maad_pkg::TOLERANCE_RESET;
            verdict_q.delete();
        end else begin
            // config access phase
            if (i_psel && i_penable && i_pready) begin
                if (i_pwrite) begin
                    if (i_paddr == {maad_pkg::REG_THRESHOLD, 2'b00})
                        threshold = i_pwdata[maad_pkg::DATA_W-1:0];
                    else if (i_paddr == {maad_pkg::REG_TOLERANCE, 2'b00})
                        tolerance = i_pwdata[maad_pkg::DATA_W-1:0];
                end else if (i_paddr == {maad_pkg::REG_THRESHOLD, 2'b00}) begin
                    check_field("threshold readback", 32'(threshold),
                                32'(i_prdata[maad_pkg::DATA_W-1:0]));
                end else if (i_paddr == {maad_pkg::REG_TOLERANCE, 2'b00}) begin
                    check_field("tolerance readback", 32'(tolerance),
                                32'(i_prdata[maad_pkg::DATA_W-1:0]));
                end
            end
            // result word
            if (i_out_valid && !i_out_stall) begin
                if (verdict_q.size() == 0) begin
                    miss_count++;
                    $display("%0t: unexpected result word, expected none, got %h",
                             $time, i_out_word);
                end else begin
                    want = verdict_q.pop_front();
                    check_field("average", 32'(want.average), 32'(i_out_word.average));
                    check_field("above_threshold", 32'(want.above_threshold),
                                32'(i_out_word.above_threshold));
                    check_field("matched_count", 32'(want.matched_count),
                                32'(i_out_word.matched_count));
                    check_field("alert", 32'(want.alert), 32'(i_out_word.alert));
                end
            end
            // input word
            if (i_in_valid && !i_in_stall)
                verdict_q.push_back(advance_window(i_in_word));
        end
        open_count = verdict_q.size();
    end

endmodule

/* dv/tb_moving_average_alert_detector.sv */
`timescale 1ns / 1ps
// testbench top: stimulus, idling and verdict for the moving average alert detector
module tb_moving_average_alert_detector;

    // receiver hold-off long enough to back the pipeline up into the input
    localparam int HOLD_CYCLES  = 60;
    localparam int HOLD_ITEMS   = 40;
    localparam int NUM_PHASES   = 8;
    localparam int PHASE_ITEMS  = 185;
    localparam int DRAIN_CYCLES = 8;

    logic                        clk       = 1'b0;
    logic                        rst_n     = 1'b0;
    logic                        in_valid  = 1'b0;
    maad_pkg::t_in_word          in_word   = '0;
    logic                        in_stall;
    logic                        out_valid;
    maad_pkg::t_out_word         out_word;
    logic                        out_stall = 1'b0;
    logic                        psel      = 1'b0;
    logic                        penable   = 1'b0;
    logic                        pwrite    = 1'b0;
    logic [maad_pkg::ADDR_W-1:0] paddr     = '0;
    logic [31:0]                 pwdata    = '0;
    logic [31:0]                 prdata;
    logic                        pready;
    int                          fail_count;
    int                          pending;

    // idling controls: gaps for the sender, stalls for the receiver, hold-off request from sender side to receiver
    bit gaps_on      = 1'b1;
    bit stalls_on    = 1'b1;
    bit hold_pending = 1'b0;

    always #2 clk = ~clk;

    moving_average_alert_detector u_top (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .i_in_word   (in_word),
        .o_in_stall  (in_stall),
        .o_out_valid (out_valid),
        .o_out_word  (out_word),
        .i_out_stall (out_stall),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    maad_alert_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_word    (in_word),
        .i_in_stall   (in_stall),
        .i_out_valid  (out_valid),
        .i_out_word   (out_word),
        .i_out_stall  (out_stall),
        .i_psel       (psel),
        .i_penable    (penable),
        .i_pwrite     (pwrite),
        .i_paddr      (paddr),
        .i_pwdata     (pwdata),
        .i_prdata     (prdata),
        .i_pready     (pready),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // saturate to the 16 bit sample range
    function automatic logic [maad_pkg::DATA_W-1:0] clamp16(int v);
        if (v < 0)
            return '0;
        if (v > 65535)
            return '1;
        return v[maad_pkg::DATA_W-1:0];
    endfunction

    function automatic maad_pkg::t_in_word make_word(int rd, int l, int r, int u, int d,
                                                     logic [3:0] present);
        maad_pkg::t_in_word w;
        w.reading           = clamp16(rd);
        w.left_value        = clamp16(l);
        w.right_value       = clamp16(r);
        w.up_value          = clamp16(u);
        w.down_value        = clamp16(d);
        w.neighbour_present = present;
        return w;
    endfunction

    // noise word: every field uniform over its full range
    function automatic maad_pkg::t_in_word random_word();
        maad_pkg::t_in_word w;
        w.reading           = maad_pkg::DATA_W'($urandom());
        w.left_value        = maad_pkg::DATA_W'($urandom());
        w.right_value       = maad_pkg::DATA_W'($urandom());
        w.up_value          = maad_pkg::DATA_W'($urandom());
        w.down_value        = maad_pkg::DATA_W'($urandom());
        w.neighbour_present = 4'($urandom_range(0, 15));
        return w;
    endfunction

    // readings held near a level so the mean settles there, neighbours scattered
    // around it by about the tolerance so matches and near misses both show up
    function automatic maad_pkg::t_in_word shaped_word(int centre, int jitter, int spread);
        maad_pkg::t_in_word w;
        w.reading           = clamp16(centre + int'($urandom_range(0, 2 * jitter)) - jitter);
        w.left_value        = clamp16(centre + int'($urandom_range(0, 2 * spread)) - spread);
        w.right_value       = clamp16(centre + int'($urandom_range(0, 2 * spread)) - spread);
        w.up_value          = clamp16(centre + int'($urandom_range(0, 2 * spread)) - spread);
        w.down_value        = clamp16(centre + int'($urandom_range(0, 2 * spread)) - spread);
        w.neighbour_present = $urandom_range(0, 1) ? 4'hF : 4'($urandom_range(0, 15));
        return w;
    endfunction

    // offer one word and hold it until taken, then maybe drop valid for a burst
    task automatic send_word(input maad_pkg::t_in_word w);
        in_valid <= 1'b1;
        in_word  <= w;
        do @(posedge clk); while (in_stall);
        @(negedge clk);
        if (gaps_on && $urandom_range(0, 5) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(negedge clk);
        end
    endtask

    // one config transfer: setup phase then access phase
    task automatic apb_access(input bit wr, input logic [maad_pkg::ADDR_W-1:0] addr,
                              input logic [31:0] data);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= addr;
        pwdata  <= data;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // program both registers, read them back, then stream shaped segments and noise
    task automatic run_phase(input int thr, input int tol, input bit hold);
        int seg_left;
        int centre;
        int jitter;
        int spread;
        seg_left = 0;
        centre   = 0;
        jitter   = 0;
        spread   = (tol == 0) ? 3 : ((tol > 2000) ? 3000 : tol + tol / 2);
        apb_access(1'b1, {maad_pkg::REG_THRESHOLD, 2'b00}, 32'(thr));
        apb_access(1'b1, {maad_pkg::REG_TOLERANCE, 2'b00}, 32'(tol));
        apb_access(1'b0, {maad_pkg::REG_THRESHOLD, 2'b00}, '0);
        apb_access(1'b0, {maad_pkg::REG_TOLERANCE, 2'b00}, '0);
        if (hold) begin
            // receiver sits on stall while the sender keeps pushing
            gaps_on      = 1'b0;
            hold_pending = 1'b1;
        end
        for (int k = 0; k < PHASE_ITEMS; k++) begin
            if (hold && k == HOLD_ITEMS)
                gaps_on = 1'b1;
            if (seg_left == 0) begin
                seg_left = $urandom_range(12, 40);
                // an exact level lets neighbours land right on the mean
                jitter   = $urandom_range(0, 1) ? 0 : int'($urandom_range(1, 4));
                case ($urandom_range(0, 9))
                    0:          centre = 0;
                    1:          centre = 65535;
                    2, 3, 4, 5: centre = thr + int'($urandom_range(0, 4000)) - 2000;
                    default:    centre = $urandom_range(0, 65535);
                endcase
            end
            seg_left--;
            if ($urandom_range(0, 9) == 0)
                send_word(random_word());
            else
                send_word(shaped_word(centre, jitter, spread));
        end
        in_valid <= 1'b0;
    endtask

    // receiver: random stall bursts, plus the one long hold-off on request
    initial begin
        forever begin
            @(negedge clk);
            if (hold_pending) begin
                hold_pending = 1'b0;
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(negedge clk);
                out_stall <= 1'b0;
            end else if (stalls_on && $urandom_range(0, 7) == 0) begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 7)) @(negedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    // stimulus and verdict
    initial begin
        int phase_thr [NUM_PHASES];
        int phase_tol [NUM_PHASES];

        // register settings per phase, extremes first, zero tolerance in phase 3
        phase_thr = '{6000, 0, 65535, 0, 0, 40000, 0, 0};
        phase_tol = '{100, 65535, 1, 0, 0, 300, 0, 0};
        phase_thr[3] = $urandom_range(0, 65535);
        phase_thr[4] = $urandom_range(0, 65535);
        phase_tol[4] = $urandom_range(1, 500);
        phase_thr[6] = $urandom_range(0, 65535);
        phase_tol[6] = $urandom_range(1, 65535);
        phase_thr[7] = $urandom_range(0, 65535);
        phase_tol[7] = $urandom_range(1, 2000);

        repeat (8) @(negedge clk);
        rst_n <= 1'b1;

        // reset values of both registers
        apb_access(1'b0, {maad_pkg::REG_THRESHOLD, 2'b00}, '0);
        apb_access(1'b0, {maad_pkg::REG_TOLERANCE, 2'b00}, '0);

        // directed: field extremes first
        send_word(make_word(0, 0, 0, 0, 0, 4'h0));
        send_word(make_word(65535, 65535, 65535, 65535, 65535, 4'hF));
        // ten equal readings flush the window so the mean is exactly 7000
        for (int k = 0; k < maad_pkg::WINDOW; k++) begin
            send_word(make_word(7000, (k % 2) ? 65535 : 0, (k % 2) ? 0 : 65535,
                                (k % 3) ? 65535 : 0, 0, 4'(k + 3)));
        end
        // mean 7000, threshold 6000, tolerance 100
        send_word(make_word(7000, 7000, 7001, 6999, 7099, 4'hF)); // equal one misses
        send_word(make_word(7000, 7100, 6900, 7000, 6901, 4'hF)); // tolerance edge
        send_word(make_word(7000, 7001, 6999, 7002, 6998, 4'h0)); // none present
        send_word(make_word(7000, 7001, 6999, 0, 0, 4'b0011));    // exactly two
        send_word(make_word(7000, 7000, 7000, 7000, 7000, 4'hF)); // all equal
        in_valid <= 1'b0;

        for (int p = 0; p < NUM_PHASES; p++) begin
            // config only while idle: every expected result has to be back
            wait (pending == 0);
            if (p == NUM_PHASES - 1) begin
                // last stretch runs flat out on both sides
                gaps_on   = 1'b0;
                stalls_on = 1'b0;
            end
            run_phase(phase_thr[p], phase_tol[p], p == 4);
        end

        wait (pending == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    // watchdog
    initial begin
        #2000000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule

/* files.f */
hw/rtl/maad_pkg.sv
hw/rtl/maad_window.sv
hw/rtl/maad_divide.sv
hw/rtl/maad_lane.sv
hw/rtl/maad_merge.sv
hw/rtl/moving_average_alert_detector.sv
dv/maad_alert_checker.sv
dv/tb_moving_average_alert_detector.sv
